@@ hdl/vna_pkg.sv @@
`default_nettype none
package vna_pkg;

  localparam int POS_W   = 24;
  localparam int DIFF_W  = 25;
  localparam int PROD_W  = 50;
  localparam int CROSS_W = 52;
  localparam int MAG_W   = 51;
  localparam int NORM_W  = 20;
  localparam int SQ_W    = 42;
  localparam int ROOT_W  = 22;
  localparam int DIV_W   = 35;
  localparam int SUM_W   = 32;
  localparam int TALLY_W = 16;
  localparam int F_W     = 16;
  localparam int EPOCH_W = 8;
  localparam int CNT_W   = 6;
  localparam int CORNER_W = 11;
  localparam int SLOT_W  = 10;
  localparam int POSW3   = 3 * POS_W;
  localparam int SUMREC_W = 3 * SUM_W + TALLY_W;

  // Step counts of the iterative units.
  localparam int SQRT_STEPS = SQ_W / 2;
  localparam int DIV_STEPS  = DIV_W;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_FACE  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RS_A    = 2'd0,
    RS_B    = 2'd1,
    RS_C    = 2'd2,
    RS_SLOT = 2'd3
  } rsel_t;

  typedef enum logic [3:0] {
    MS_WY_UZ = 4'd0,
    MS_WZ_UY = 4'd1,
    MS_WZ_UX = 4'd2,
    MS_WX_UZ = 4'd3,
    MS_WX_UY = 4'd4,
    MS_WY_UX = 4'd5,
    MS_SQ0   = 4'd6,
    MS_SQ1   = 4'd7,
    MS_SQ2   = 4'd8
  } mul_sel_t;

  typedef enum logic [4:0] {
    S_SWEEP,
    S_IDLE,
    S_LOAD,
    S_CLEAR,
    S_FETCH,
    S_CHECK,
    S_CROSS,
    S_NLOAD,
    S_RDV,
    S_VLOAD,
    S_SHIFT,
    S_SQ,
    S_SQCHK,
    S_SQRT,
    S_DIVI,
    S_DIV,
    S_DIVS,
    S_RESULT,
    S_ACC_RD,
    S_ACC_WR
  } state_t;

  typedef struct packed {
    op_t                       op;
    logic [SLOT_W-1:0]         vertex_slot;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [POS_W-1:0]   pos_z;
    logic [CORNER_W-1:0]       corner_a;
    logic [CORNER_W-1:0]       corner_b;
    logic [CORNER_W-1:0]       corner_c;
  } vna_in_t;

  typedef struct packed {
    logic signed [F_W-1:0] normal_x;
    logic signed [F_W-1:0] normal_y;
    logic signed [F_W-1:0] normal_z;
    logic                  no_normal;
  } vna_out_t;

  typedef struct packed {
    logic       capture;
    logic       load;
    logic       bump;
    logic       sweep;
    rsel_t      rsel;
    logic       fetch_cap;
    logic [1:0] lane;
    logic       check_load;
    logic       mul_en;
    mul_sel_t   mul_sel;
    logic       cross_acc;
    mul_sel_t   acc_sel;
    logic       sq_acc;
    logic       sq_first;
    logic       vload_cross;
    logic       vload_vtx;
    logic       shift;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       div_store;
    logic       zero_f;
    logic       acc_wr;
    logic       emit;
  } vna_cmd_t;

  typedef struct packed {
    op_t  op;
    logic face_ok;
    logic vtx_ok;
    logic shift_need;
    logic sq_zero;
    logic epoch_wrap;
    logic sweep_last;
  } vna_sts_t;

endpackage
`default_nettype wire

@@ hdl/vna_ram.sv @@
`default_nettype none
module vna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ hdl/vna_ctrl.sv @@
`default_nettype none
module vna_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire vna_pkg::op_t      in_op,
  input  wire vna_pkg::vna_sts_t sts,
  output logic                   busy,
  output vna_pkg::vna_cmd_t      cmd
);
  import vna_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       lane_r, lane_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
      cnt_r   <= '0;
      lane_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      lane_r  <= lane_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // Next state and step counters.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    lane_nxt  = lane_r;
    case (state_r)
      S_SWEEP: begin
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cnt_nxt  = '0;
        lane_nxt = '0;
        if (start) begin
          case (in_op)
            OP_LOAD:  state_nxt = S_LOAD;
            OP_FACE:  state_nxt = S_FETCH;
            OP_READ:  state_nxt = S_RDV;
            OP_CLEAR: state_nxt = S_CLEAR;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOAD: state_nxt = S_IDLE;
      S_CLEAR: begin
        state_nxt = sts.epoch_wrap ? S_SWEEP : S_IDLE;
      end
      S_FETCH: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(3)) begin
          cnt_nxt   = '0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = sts.face_ok ? S_CROSS : S_IDLE;
      end
      S_CROSS: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(6)) begin
          cnt_nxt   = '0;
          state_nxt = S_NLOAD;
        end
      end
      S_NLOAD: state_nxt = S_SHIFT;
      S_RDV:   state_nxt = S_VLOAD;
      S_VLOAD: begin
        state_nxt = sts.vtx_ok ? S_SHIFT : S_RESULT;
      end
      S_SHIFT: begin
        cnt_nxt = '0;
        if (!sts.shift_need) begin
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(3)) begin
          cnt_nxt   = '0;
          state_nxt = S_SQCHK;
        end
      end
      S_SQCHK: begin
        lane_nxt = '0;
        if (sts.sq_zero) begin
          state_nxt = (sts.op == OP_READ) ? S_RESULT : S_ACC_RD;
        end else begin
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DIVI;
        end
      end
      S_DIVI: begin
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DIVS;
        end
      end
      S_DIVS: begin
        if (lane_r == 2'd2) begin
          lane_nxt  = '0;
          state_nxt = (sts.op == OP_READ) ? S_RESULT : S_ACC_RD;
        end else begin
          lane_nxt  = lane_r + 1'b1;
          state_nxt = S_DIVI;
        end
      end
      S_RESULT: state_nxt = S_IDLE;
      S_ACC_RD: state_nxt = S_ACC_WR;
      S_ACC_WR: begin
        if (lane_r == 2'd2) begin
          state_nxt = S_IDLE;
        end else begin
          lane_nxt  = lane_r + 1'b1;
          state_nxt = S_ACC_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd      = '0;
    cmd.rsel = RS_SLOT;
    cmd.lane = lane_r;
    case (state_r)
      S_SWEEP: cmd.sweep = 1'b1;
      S_IDLE:  cmd.capture = start;
      S_LOAD:  cmd.load = 1'b1;
      S_CLEAR: cmd.bump = 1'b1;
      S_FETCH: begin
        // Corner reads go out back to back; each one's data returns in the next cycle.
        cmd.rsel      = rsel_t'(cnt_r[1:0]);
        cmd.fetch_cap = (cnt_r != '0);
        cmd.lane      = cnt_r[1:0] - 2'd1;
      end
      S_CHECK: cmd.check_load = 1'b1;
      S_CROSS: begin
        cmd.mul_en    = (cnt_r < CNT_W'(6));
        cmd.mul_sel   = mul_sel_t'(cnt_r[3:0]);
        cmd.cross_acc = (cnt_r != '0);
        cmd.acc_sel   = mul_sel_t'(cnt_r[3:0] - 4'd1);
      end
      S_NLOAD: cmd.vload_cross = 1'b1;
      S_RDV:   cmd.rsel = RS_SLOT;
      S_VLOAD: begin
        cmd.vload_vtx = sts.vtx_ok;
        cmd.zero_f    = !sts.vtx_ok;
      end
      S_SHIFT: cmd.shift = sts.shift_need;
      S_SQ: begin
        cmd.mul_en   = (cnt_r < CNT_W'(3));
        cmd.mul_sel  = mul_sel_t'(4'(MS_SQ0) + cnt_r[3:0]);
        cmd.sq_acc   = (cnt_r != '0);
        cmd.sq_first = (cnt_r == CNT_W'(1));
      end
      S_SQCHK: begin
        cmd.zero_f    = sts.sq_zero;
        cmd.sqrt_init = !sts.sq_zero;
      end
      S_SQRT:   cmd.sqrt_step = 1'b1;
      S_DIVI:   cmd.div_init = 1'b1;
      S_DIV:    cmd.div_step = 1'b1;
      S_DIVS:   cmd.div_store = 1'b1;
      S_RESULT: cmd.emit = 1'b1;
      S_ACC_RD: cmd.rsel = rsel_t'(lane_r);
      S_ACC_WR: cmd.acc_wr = 1'b1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/vna_dp.sv @@
`default_nettype none
module vna_dp #(
  parameter int MAX_VERTICES = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire vna_pkg::vna_in_t  in_req,
  input  wire vna_pkg::vna_cmd_t cmd,
  output vna_pkg::vna_sts_t      sts,
  output logic                   out_valid,
  output vna_pkg::vna_out_t      out_rsp
);
  import vna_pkg::*;

  // Corners reach 2047, so no entry beyond that can ever be addressed.
  localparam int DEPTH = (MAX_VERTICES < 2048) ? MAX_VERTICES : 2048;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [16:0] MAXV = 17'(MAX_VERTICES);

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] a,
    input logic signed [F_W-1:0]   b
  );
    logic signed [SUM_W:0] t;
    t = SUM_W'(0) + {a[SUM_W-1], a} + {{(SUM_W+1-F_W){b[F_W-1]}}, b};
    if (t[SUM_W] != t[SUM_W-1]) begin
      sat_add = t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = t[SUM_W-1:0];
    end
  endfunction

  vna_in_t                   req_r;
  logic [EPOCH_W-1:0]        epoch_r;
  logic [AW-1:0]             sweep_r;
  logic [POSW3-1:0]          pw_r [3];
  logic [2:0]                okv_r;
  logic signed [DIFF_W-1:0]  u_r [3];
  logic signed [DIFF_W-1:0]  w_r [3];
  logic signed [PROD_W-1:0]  p_r;
  logic signed [CROSS_W-1:0] n_r [3];
  logic [2:0]                sgn_r;
  logic [MAG_W-1:0]          mag_r [3];
  logic [SQ_W-1:0]           sq_r;
  logic [SQ_W-1:0]           rem_sq_r;
  logic [SQ_W-1:0]           root_r;
  logic [SQ_W-1:0]           bit_r;
  logic [DIV_W-1:0]          dq_r;
  logic [ROOT_W-1:0]         drem_r;
  logic signed [F_W-1:0]     f_r [3];
  logic                      nodir_r;
  logic                      out_valid_r;
  vna_out_t                  out_rsp_r;

  // Address decode.
  logic [CORNER_W-1:0] corner [3];
  logic [CORNER_W-1:0] cidx [3];
  logic [CORNER_W-1:0] slot_ext;
  logic [2:0]          corner_in;
  logic                slot_ok;
  logic [AW-1:0]       raddr;
  logic [AW-1:0]       slot_addr;

  always_comb begin
    corner[0] = req_r.corner_a;
    corner[1] = req_r.corner_b;
    corner[2] = req_r.corner_c;
    for (int i = 0; i < 3; i++) begin
      cidx[i]      = corner[i] - CORNER_W'(1);
      corner_in[i] = (corner[i] != '0) && ({6'b0, corner[i]} <= MAXV);
    end
    slot_ext  = {1'b0, req_r.vertex_slot};
    slot_addr = slot_ext[AW-1:0];
    slot_ok   = ({7'b0, req_r.vertex_slot} < MAXV);
    case (cmd.rsel)
      RS_A:    raddr = cidx[0][AW-1:0];
      RS_B:    raddr = cidx[1][AW-1:0];
      RS_C:    raddr = cidx[2][AW-1:0];
      default: raddr = slot_addr;
    endcase
  end

  // Storage.
  logic [POSW3-1:0]    pos_rd;
  logic [SUMREC_W-1:0] sum_rd;
  logic [EPOCH_W-1:0]  ep_rd;
  logic                pos_we, sum_we, ep_we;
  logic [AW-1:0]       sum_wa, ep_wa;
  logic [SUMREC_W-1:0] sum_wd;
  logic [EPOCH_W-1:0]  ep_wd;
  logic [AW-1:0]       acc_addr;
  logic signed [SUM_W-1:0] nsum [3];
  logic [TALLY_W-1:0]  tally_rd;

  always_comb begin
    acc_addr = cidx[cmd.lane][AW-1:0];
    tally_rd = sum_rd[SUMREC_W-1 -: TALLY_W];
    for (int i = 0; i < 3; i++) begin
      nsum[i] = sat_add(sum_rd[i*SUM_W +: SUM_W], f_r[i]);
    end
    pos_we = cmd.load && slot_ok;
    sum_we = pos_we || cmd.acc_wr;
    sum_wa = cmd.acc_wr ? acc_addr : slot_addr;
    if (cmd.acc_wr) begin
      sum_wd = {(tally_rd == '1) ? tally_rd : tally_rd + 1'b1, nsum[2], nsum[1], nsum[0]};
    end else begin
      sum_wd = '0;
    end
    ep_we = pos_we || cmd.sweep;
    ep_wa = cmd.sweep ? sweep_r : slot_addr;
    ep_wd = cmd.sweep ? '0 : epoch_r;
  end

  vna_ram #(.WIDTH(POSW3), .DEPTH(DEPTH)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (slot_addr),
    .wdata ({req_r.pos_z, req_r.pos_y, req_r.pos_x}),
    .raddr (raddr),
    .rdata (pos_rd)
  );

  vna_ram #(.WIDTH(SUMREC_W), .DEPTH(DEPTH)) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_wa),
    .wdata (sum_wd),
    .raddr (raddr),
    .rdata (sum_rd)
  );

  vna_ram #(.WIDTH(EPOCH_W), .DEPTH(DEPTH)) u_epoch_ram (
    .clk   (clk),
    .we    (ep_we),
    .waddr (ep_wa),
    .wdata (ep_wd),
    .raddr (raddr),
    .rdata (ep_rd)
  );

  // Shared multiplier operands.
  logic signed [DIFF_W-1:0] ma, mb;

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mul_sel)
      MS_WY_UZ: begin ma = w_r[1]; mb = u_r[2]; end
      MS_WZ_UY: begin ma = w_r[2]; mb = u_r[1]; end
      MS_WZ_UX: begin ma = w_r[2]; mb = u_r[0]; end
      MS_WX_UZ: begin ma = w_r[0]; mb = u_r[2]; end
      MS_WX_UY: begin ma = w_r[0]; mb = u_r[1]; end
      MS_WY_UX: begin ma = w_r[1]; mb = u_r[0]; end
      MS_SQ0: begin
        ma = {5'b0, mag_r[0][NORM_W-1:0]};
        mb = ma;
      end
      MS_SQ1: begin
        ma = {5'b0, mag_r[1][NORM_W-1:0]};
        mb = ma;
      end
      MS_SQ2: begin
        ma = {5'b0, mag_r[2][NORM_W-1:0]};
        mb = ma;
      end
      default: ;
    endcase
  end

  logic signed [CROSS_W-1:0] p_ext;
  assign p_ext = CROSS_W'(p_r);

  // Vector loading and magnitude split.
  logic signed [CROSS_W-1:0] vsrc [3];
  logic signed [CROSS_W-1:0] vneg [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (cmd.vload_cross) begin
        vsrc[i] = n_r[i];
      end else begin
        vsrc[i] = CROSS_W'($signed(sum_rd[i*SUM_W +: SUM_W]));
      end
      vneg[i] = -vsrc[i];
    end
  end

  logic [MAG_W-1:0] mag_or;
  assign mag_or = mag_r[0] | mag_r[1] | mag_r[2];

  // Integer square root, one result bit per step.
  logic [SQ_W:0] rb_sum;
  assign rb_sum = {1'b0, root_r} + {1'b0, bit_r};

  // Restoring divider.
  logic [ROOT_W-1:0] len;
  logic [ROOT_W:0]   trial;
  logic              tfit;
  logic [DIV_W-1:0]  dividend;
  logic [F_W-1:0]    qmag;

  always_comb begin
    len      = root_r[ROOT_W-1:0];
    trial    = {drem_r, dq_r[DIV_W-1]};
    tfit     = (trial >= {1'b0, len});
    dividend = DIV_W'({mag_r[cmd.lane][NORM_W-1:0], 14'b0}) + DIV_W'(len >> 1);
    qmag     = dq_r[F_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r     <= EPOCH_W'(1);
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.sweep) begin
        sweep_r <= sweep_r + 1'b1;
      end
      if (cmd.bump) begin
        sweep_r <= '0;
        epoch_r <= (epoch_r == '1) ? EPOCH_W'(1) : epoch_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r   <= in_req;
      nodir_r <= 1'b0;
    end
    if (cmd.fetch_cap) begin
      pw_r[cmd.lane]  <= pos_rd;
      okv_r[cmd.lane] <= (ep_rd == epoch_r);
    end
    if (cmd.check_load) begin
      for (int i = 0; i < 3; i++) begin
        u_r[i] <= DIFF_W'($signed(pw_r[0][i*POS_W +: POS_W]))
                - DIFF_W'($signed(pw_r[1][i*POS_W +: POS_W]));
        w_r[i] <= DIFF_W'($signed(pw_r[2][i*POS_W +: POS_W]))
                - DIFF_W'($signed(pw_r[1][i*POS_W +: POS_W]));
      end
    end
    if (cmd.mul_en) begin
      p_r <= ma * mb;
    end
    if (cmd.cross_acc) begin
      case (cmd.acc_sel)
        MS_WY_UZ: n_r[0] <= p_ext;
        MS_WZ_UY: n_r[0] <= n_r[0] - p_ext;
        MS_WZ_UX: n_r[1] <= p_ext;
        MS_WX_UZ: n_r[1] <= n_r[1] - p_ext;
        MS_WX_UY: n_r[2] <= p_ext;
        MS_WY_UX: n_r[2] <= n_r[2] - p_ext;
        default: ;
      endcase
    end
    if (cmd.vload_cross || cmd.vload_vtx) begin
      for (int i = 0; i < 3; i++) begin
        sgn_r[i] <= vsrc[i][CROSS_W-1];
        mag_r[i] <= vsrc[i][CROSS_W-1] ? vneg[i][MAG_W-1:0] : vsrc[i][MAG_W-1:0];
      end
    end
    if (cmd.shift) begin
      for (int i = 0; i < 3; i++) begin
        mag_r[i] <= mag_r[i] >> 1;
      end
    end
    if (cmd.sq_acc) begin
      sq_r <= (cmd.sq_first ? '0 : sq_r) + p_r[SQ_W-1:0];
    end
    if (cmd.sqrt_init) begin
      rem_sq_r <= sq_r;
      root_r   <= '0;
      bit_r    <= SQ_W'(1) << (SQ_W - 2);
    end
    if (cmd.sqrt_step) begin
      if ({1'b0, rem_sq_r} >= rb_sum) begin
        rem_sq_r <= rem_sq_r - rb_sum[SQ_W-1:0];
        root_r   <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.div_init) begin
      dq_r   <= dividend;
      drem_r <= '0;
    end
    if (cmd.div_step) begin
      dq_r <= {dq_r[DIV_W-2:0], tfit};
      drem_r <= tfit ? ROOT_W'(trial - {1'b0, len}) : trial[ROOT_W-1:0];
    end
    if (cmd.div_store) begin
      f_r[cmd.lane] <= sgn_r[cmd.lane] ? -$signed(qmag) : $signed(qmag);
    end
    if (cmd.zero_f) begin
      for (int i = 0; i < 3; i++) begin
        f_r[i] <= '0;
      end
      nodir_r <= 1'b1;
    end
    if (cmd.emit) begin
      out_rsp_r.normal_x  <= f_r[0];
      out_rsp_r.normal_y  <= f_r[1];
      out_rsp_r.normal_z  <= f_r[2];
      out_rsp_r.no_normal <= nodir_r;
    end
  end

  always_comb begin
    sts.op         = req_r.op;
    sts.face_ok    = (&corner_in) && (&okv_r);
    sts.vtx_ok     = slot_ok && (ep_rd == epoch_r) && (tally_rd != '0);
    sts.shift_need = |mag_or[MAG_W-1:NORM_W];
    sts.sq_zero    = (sq_r == '0);
    sts.epoch_wrap = (epoch_r == '1);
    sts.sweep_last = (sweep_r == AW'(DEPTH - 1));
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule
`default_nettype wire

@@ hdl/vertex_normal_accumulator.sv @@
// Channel   Ports                       Handshake
// request   start, busy, in_req         taken when start is high and busy is low
// result    out_valid, out_rsp          one-cycle strobe, always taken
//
// A vertex read needs at most 12 normalizing shifts and a face at most 30. A read of a
// vertex with no faces and a face with a bad corner end early, and a degenerate face
// skips the square root and the divider. The time is set by the sequencer driving one
// shared multiplier, a bit-serial square root (21 steps) and a bit-serial divider (35
// steps per component, three components).
// After reset the block sweeps every entry of the epoch memory with busy high; every
// 255th mesh clear repeats that sweep. The result side cannot stall: a read's result
// appears once, in the cycle after its work ends, when the next request may already be
// accepted.
`default_nettype none
module vertex_normal_accumulator #(
  parameter int MAX_VERTICES = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire vna_pkg::vna_in_t in_req,
  output logic                  out_valid,
  output vna_pkg::vna_out_t     out_rsp
);
  import vna_pkg::*;

  // The controller sequences each request; the datapath holds the three memories
  // (positions, running sums with face counts, and epoch marks) and the arithmetic.
  vna_cmd_t cmd;
  vna_sts_t sts;

  vna_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_req.op),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  // A vertex counts as present when its epoch mark equals the current epoch, so a
  // mesh clear is a single increment, plus a pass over every entry when the epoch wraps.
  vna_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule
`default_nettype wire

@@ dv/vertex_normal_accumulator_test.sv @@
`timescale 1ns / 100ps
`default_nettype none
module vertex_normal_accumulator_test;
  import vna_pkg::*;

  localparam int NVERT = 1024;

  // Reference copy of the mesh state, kept by the scoreboard's owner.
  class normal_scoreboard;
    int signed pos_x[NVERT];
    int signed pos_y[NVERT];
    int signed pos_z[NVERT];
    int signed acc_x[NVERT];
    int signed acc_y[NVERT];
    int signed acc_z[NVERT];
    int unsigned tally[NVERT];
    bit loaded[NVERT];
    vna_out_t pending[$];
    int errors;

    function void clear_all();
      foreach (loaded[i]) loaded[i] = 1'b0;
      pending.delete();
      errors = 0;
    endfunction

    // Scales a vector to unit length in Q1.14; returns 0 when it has no direction.
    function bit to_unit(input longint v[3], output int signed r[3]);
      longint unsigned mag[3];
      longint unsigned m, sq, len, q, bitv, root, n;
      int sh;
      m = 0;
      sq = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = v[i] < 0 ? -v[i] : v[i];
        if (mag[i] > m) m = mag[i];
      end
      sh = 0;
      while ((m >> sh) >= (64'd1 << 20)) sh++;
      for (int i = 0; i < 3; i++) begin
        mag[i] = mag[i] >> sh;
        sq += mag[i] * mag[i];
      end
      r[0] = 0; r[1] = 0; r[2] = 0;
      if (sq == 0) return 1'b0;
      n = sq;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= root + bitv) begin
          n -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      len = root;
      for (int i = 0; i < 3; i++) begin
        q = (mag[i] * 16384 + len / 2) / len;
        r[i] = v[i] < 0 ? -int'(q) : int'(q);
      end
      return 1'b1;
    endfunction

    function int signed sat32(input int signed a, input int signed b);
      longint t;
      t = longint'(a) + longint'(b);
      if (t > 64'sd2147483647) return 32'sh7fffffff;
      if (t < -64'sd2147483648) return 32'sh80000000;
      return int'(t);
    endfunction

    function bit corner_usable(input int unsigned c);
      return c >= 1 && c <= NVERT && loaded[c-1];
    endfunction

    // Updates the mesh copy for one accepted request and queues any read result.
    function void note_request(input vna_in_t rq);
      int unsigned ix[3];
      longint ux, uy, uz, wx, wy, wz;
      longint nv[3];
      int signed f[3];
      vna_out_t e;
      bit ok;
      case (rq.op)
        OP_LOAD: begin
          pos_x[rq.vertex_slot] = rq.pos_x;
          pos_y[rq.vertex_slot] = rq.pos_y;
          pos_z[rq.vertex_slot] = rq.pos_z;
          acc_x[rq.vertex_slot] = 0;
          acc_y[rq.vertex_slot] = 0;
          acc_z[rq.vertex_slot] = 0;
          tally[rq.vertex_slot] = 0;
          loaded[rq.vertex_slot] = 1'b1;
        end
        OP_FACE: begin
          if (corner_usable(rq.corner_a) && corner_usable(rq.corner_b) &&
              corner_usable(rq.corner_c)) begin
            ix[0] = rq.corner_a - 1;
            ix[1] = rq.corner_b - 1;
            ix[2] = rq.corner_c - 1;
            ux = longint'(pos_x[ix[0]]) - pos_x[ix[1]];
            uy = longint'(pos_y[ix[0]]) - pos_y[ix[1]];
            uz = longint'(pos_z[ix[0]]) - pos_z[ix[1]];
            wx = longint'(pos_x[ix[2]]) - pos_x[ix[1]];
            wy = longint'(pos_y[ix[2]]) - pos_y[ix[1]];
            wz = longint'(pos_z[ix[2]]) - pos_z[ix[1]];
            nv[0] = wy * uz - wz * uy;
            nv[1] = wz * ux - wx * uz;
            nv[2] = wx * uy - wy * ux;
            ok = to_unit(nv, f);
            for (int i = 0; i < 3; i++) begin
              acc_x[ix[i]] = sat32(acc_x[ix[i]], f[0]);
              acc_y[ix[i]] = sat32(acc_y[ix[i]], f[1]);
              acc_z[ix[i]] = sat32(acc_z[ix[i]], f[2]);
              if (tally[ix[i]] != 65535) tally[ix[i]]++;
            end
          end
        end
        OP_CLEAR: begin
          foreach (loaded[i]) loaded[i] = 1'b0;
        end
        default: begin
          f[0] = 0; f[1] = 0; f[2] = 0;
          ok = 1'b0;
          if (loaded[rq.vertex_slot] && tally[rq.vertex_slot] != 0) begin
            nv[0] = acc_x[rq.vertex_slot];
            nv[1] = acc_y[rq.vertex_slot];
            nv[2] = acc_z[rq.vertex_slot];
            ok = to_unit(nv, f);
          end
          e.normal_x = f[0][15:0];
          e.normal_y = f[1][15:0];
          e.normal_z = f[2][15:0];
          e.no_normal = !ok;
          pending.push_back(e);
        end
      endcase
    endfunction

    function void check_result(input vna_out_t got);
      vna_out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.normal_x !== e.normal_x) begin
        $error("normal_x expected %0d actual %0d", e.normal_x, got.normal_x);
        errors++;
      end
      if (got.normal_y !== e.normal_y) begin
        $error("normal_y expected %0d actual %0d", e.normal_y, got.normal_y);
        errors++;
      end
      if (got.normal_z !== e.normal_z) begin
        $error("normal_z expected %0d actual %0d", e.normal_z, got.normal_z);
        errors++;
      end
      if (got.no_normal !== e.no_normal) begin
        $error("no_normal expected %0d actual %0d", e.no_normal, got.no_normal);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  vna_in_t in_req = '0;
  logic out_valid;
  vna_out_t out_rsp;

  normal_scoreboard sb;
  bit allow_gaps = 1'b1;
  // Number of vertices loaded in the current mesh; random faces mostly use them.
  int mesh_size;

  always #6 clk = ~clk;

  vertex_normal_accumulator u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_rsp(out_rsp)
  );

  // The result side cannot stall, so every strobe is checked at the edge that ends it.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_rsp);
  end

  // Presents one request and holds it until the block takes it. Start drops at the
  // accepting edge and the task returns at the next edge; busy is high in that cycle
  // anyway, so no slot is lost. A random burst of idle cycles may come first.
  task automatic send_request(input vna_in_t rq);
    int gap;
    if (allow_gaps && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req <= rq;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(rq);
    start <= 1'b0;
    in_req <= vna_in_t'({$urandom, $urandom, $urandom, $urandom});
    @(posedge clk);
  endtask

  task automatic load_vertex(input int slot, input int x, input int y, input int z);
    vna_in_t rq;
    rq = vna_in_t'({$urandom, $urandom, $urandom, $urandom});
    rq.op = OP_LOAD;
    rq.vertex_slot = SLOT_W'(slot);
    rq.pos_x = POS_W'(x);
    rq.pos_y = POS_W'(y);
    rq.pos_z = POS_W'(z);
    send_request(rq);
  endtask

  task automatic add_face(input int a, input int b, input int c);
    vna_in_t rq;
    rq = vna_in_t'({$urandom, $urandom, $urandom, $urandom});
    rq.op = OP_FACE;
    rq.corner_a = CORNER_W'(a);
    rq.corner_b = CORNER_W'(b);
    rq.corner_c = CORNER_W'(c);
    send_request(rq);
  endtask

  task automatic read_normal(input int slot);
    vna_in_t rq;
    rq = vna_in_t'({$urandom, $urandom, $urandom, $urandom});
    rq.op = OP_READ;
    rq.vertex_slot = SLOT_W'(slot);
    send_request(rq);
  endtask

  task automatic clear_mesh();
    vna_in_t rq;
    rq = vna_in_t'({$urandom, $urandom, $urandom, $urandom});
    rq.op = OP_CLEAR;
    send_request(rq);
    mesh_size = 0;
  endtask

  // Random coordinate: mostly small meshes, sometimes full-scale values.
  function automatic int rand_coord();
    if ($urandom_range(0, 4) == 0) return $signed($urandom) >>> 8;
    return $signed($urandom_range(0, 4095)) - 2048;
  endfunction

  // Picks a corner: usually a loaded vertex, now and then zero, a number beyond the mesh or any of 1 to 1024.
  function automatic int rand_corner();
    if (mesh_size == 0 || $urandom_range(0, 19) == 0) begin
      case ($urandom_range(0, 2))
        0: return 0;
        1: return $urandom_range(1025, 2047);
        default: return $urandom_range(1, 1024);
      endcase
    end
    return $urandom_range(1, mesh_size);
  endfunction

  initial begin
    int sel;
    sb = new();
    sb.clear_all();
    mesh_size = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: extremes, each operation, and the special cases.
    read_normal(5);                                   // never loaded
    read_normal(1023);
    load_vertex(0, 0, 0, 0);
    load_vertex(1, 24'sh7fffff, 0, 0);
    load_vertex(2, 0, 24'sh7fffff, 0);
    load_vertex(1023, -8388608, -8388608, 24'sh7fffff);
    read_normal(0);                                   // loaded, no faces
    add_face(1, 2, 3);
    add_face(3, 2, 1);                                // opposite winding cancels
    read_normal(1);
    add_face(1, 2, 3);
    read_normal(0);
    add_face(1, 1, 2);                                // repeated corner
    add_face(1, 2, 1024);
    add_face(0, 1, 2);                                // corner zero
    add_face(1, 2, 2047);                             // corner beyond the mesh
    add_face(1, 2, 9);                                // vertex never loaded
    read_normal(1023);
    read_normal(2);
    load_vertex(1, 16, 16, 16);                       // reload restarts the sums
    read_normal(1);
    clear_mesh();
    add_face(1, 2, 3);                                // corners now invalid
    read_normal(0);

    // Pause until every pending read has come back.
    while (sb.pending.size() != 0) @(posedge clk);

    // Random part: build a mesh, add faces, read normals, occasionally clear.
    for (int n = 0; n < 450; n++) begin
      if (n > 400) allow_gaps = 1'b0;
      sel = $urandom_range(0, 99);
      if (mesh_size < 3 || sel < 15) begin
        if (mesh_size < 64) begin
          load_vertex(mesh_size, rand_coord(), rand_coord(), rand_coord());
          mesh_size++;
        end else begin
          load_vertex($urandom_range(0, 1023), rand_coord(), rand_coord(), rand_coord());
        end
      end else if (sel < 55) begin
        add_face(rand_corner(), rand_corner(), rand_corner());
      end else if (sel < 97) begin
        read_normal($urandom_range(0, 7) == 0 ? $urandom_range(0, 1023)
                                              : $urandom_range(0, mesh_size - 1));
      end else begin
        clear_mesh();
      end
    end

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Worst case: about 480 requests, each of bounded length, plus a few sweeps take far less time than this.
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire
